FILE: design/per_breath_oxygen_valve_tuner_top_assert.svh
// Assertion macros for the per-breath oxygen valve tuner.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef PER_BREATH_OXYGEN_VALVE_TUNER_TOP_ASSERT_SVH
`define PER_BREATH_OXYGEN_VALVE_TUNER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define PBOVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PBOVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pbovt_pkg.sv
// Shared types and constants for the per-breath oxygen valve tuner.
// No dependencies; imported by the controller, the datapath and the top level.
package pbovt_pkg;

  localparam int VALVE_BITS_DEF = 12;
  localparam int VALVE_CFG_W    = 12;
  localparam int STEP_W         = 10;
  localparam int PCT_W          = 7;
  localparam int FLOW_W         = 8;
  localparam int CHK_W          = 4;
  localparam int BC_W           = 4;
  localparam int STREAK_W       = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int DRIVE_W        = 12;

  localparam int P1_W    = 17;
  localparam int P2_W    = 24;
  localparam int RECIP_W = 25;
  localparam int PROD_W  = P2_W + RECIP_W;
  localparam int Q_W     = 10;

  localparam logic [RECIP_W-1:0] RECIP_30000 = 25'd18325194;
  localparam int                 RECIP_SHIFT = 39;
  localparam logic [8:0]         VOL_SCALE   = 9'd300;
  localparam logic [8:0]         K_LOW_FIO2  = 9'd200;
  localparam logic [8:0]         K_HIGH_FIO2 = 9'd230;
  localparam logic [PCT_W-1:0]   FIO2_K_SWITCH = 7'd80;
  localparam logic [PCT_W-1:0]   FIO2_AMBIENT  = 7'd21;
  localparam logic [PCT_W-1:0]   BAND_SMALL    = 7'd2;
  localparam logic [PCT_W-1:0]   BAND_MID      = 7'd4;
  localparam logic [BC_W-1:0]    BREATH_SAT    = 4'd13;
  localparam logic [BC_W-1:0]    BOOST_BREATH  = 4'd10;
  localparam logic [CHK_W-1:0]   CHECK_LIMIT   = 4'd4;
  localparam logic [FLOW_W-1:0]  FLOW_MIN      = 8'd2;
  localparam logic [FLOW_W-1:0]  FLOW_MAX      = 8'd255;

  localparam logic              DEF_BLEND   = 1'b0;
  localparam logic [FLOW_W-1:0] DEF_PEAK_FLOW = 8'd60;
  localparam logic [STEP_W-1:0] DEF_STEP_SMALL = 10'd10;
  localparam logic [STEP_W-1:0] DEF_STEP_MID   = 10'd20;
  localparam logic [STEP_W-1:0] DEF_STEP_LARGE = 10'd40;
  localparam logic [STEP_W-1:0] DEF_BOOST      = 10'd40;
  localparam logic [VALVE_CFG_W-1:0] DEF_CEILING = 12'd3300;
  localparam logic [VALVE_CFG_W-1:0] DEF_FLOOR   = 12'd1400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_METHOD  = 3'd0,
    CFG_PEAK_FLOW     = 3'd1,
    CFG_STEP_SMALL    = 3'd2,
    CFG_STEP_MID      = 3'd3,
    CFG_STEP_LARGE    = 3'd4,
    CFG_BOOST_STEP    = 3'd5,
    CFG_VALVE_CEILING = 3'd6,
    CFG_VALVE_FLOOR   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL2,
    ST_MUL3,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul2;
    logic mul3;
    logic commit;
  } dp_cmd_t;

endpackage

FILE: design/pbovt_ctrl.sv
// Sequencing controller for the per-breath oxygen valve tuner.
// Depends on pbovt_pkg and the assertion macro header.
`include "per_breath_oxygen_valve_tuner_top_assert.svh"

module pbovt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pbovt_pkg::dp_cmd_t cmd
);
  import pbovt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
      end
      ST_MUL3: begin
        cmd.mul3 = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PBOVT_ASSERT(a_accept_starts_work, (in_valid && in_ready) |=> (state_r == ST_MUL2),
    "accepted transfer did not start the multiply sequence")
  `PBOVT_ASSERT(a_commit_sets_valid, cmd.commit |=> out_valid_r,
    "committed result not presented")
  `PBOVT_ASSERT(a_commit_never_overwrites, cmd.commit |-> (!out_valid_r || out_ready),
    "result overwritten while receiver stalls")
  `PBOVT_ASSERT(a_stall_holds_commit,
    (state_r == ST_COMMIT && out_valid_r && !out_ready) |=> (state_r == ST_COMMIT),
    "commit state left while output register busy")
  `PBOVT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (state_r == ST_IDLE && !out_valid_r),
    "reset did not clear controller")

endmodule

FILE: design/pbovt_dp.sv
// Datapath of the per-breath oxygen valve tuner: configuration, flow target
// multiplies, valve tuning state and result registers. Depends on pbovt_pkg.
module pbovt_dp #(
  parameter int VALVE_BITS = pbovt_pkg::VALVE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pbovt_pkg::dp_cmd_t                  cmd,
  input  logic                                cfg_we,
  input  logic [pbovt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbovt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_mode,
  input  logic [pbovt_pkg::PCT_W-1:0]         in_fio2_set,
  input  logic [pbovt_pkg::PCT_W-1:0]         in_o2_measured,
  input  logic [pbovt_pkg::FLOW_W-1:0]        in_mean_flow,
  input  logic [pbovt_pkg::CHK_W-1:0]         in_check_count,
  input  logic [pbovt_pkg::VALVE_CFG_W-1:0]   in_valve_load,
  output logic [pbovt_pkg::DRIVE_W-1:0]       out_valve_drive,
  output logic [pbovt_pkg::FLOW_W-1:0]        out_target_flow,
  output logic                                out_flow_updated,
  output logic                                out_tuning_active,
  output logic [pbovt_pkg::FLOW_W-1:0]        out_held_flow
);
  import pbovt_pkg::*;

  localparam int SUM_W = ((VALVE_BITS > STEP_W) ? VALVE_BITS : STEP_W) + 1;
  localparam int LIM_W = (VALVE_BITS > VALVE_CFG_W) ? VALVE_BITS : VALVE_CFG_W;

  typedef logic [VALVE_BITS-1:0] valve_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [LIM_W-1:0]      lim_t;

  localparam valve_t VALVE_MAX = '1;

  logic                   cfg_blend_r;
  logic [FLOW_W-1:0]      cfg_peak_flow_r;
  logic [STEP_W-1:0]      cfg_step_small_r, cfg_step_mid_r, cfg_step_large_r, cfg_boost_r;
  logic [VALVE_CFG_W-1:0] cfg_ceiling_r, cfg_floor_r;

  logic                   mode_r;
  logic [PCT_W-1:0]       fio2_r, ach_r;
  logic [FLOW_W-1:0]      avg_r;
  logic [CHK_W-1:0]       chk_r;
  logic [VALVE_CFG_W-1:0] load_r;

  logic [8:0]         fk;
  logic [P1_W-1:0]    p1_nxt, p1_r;
  logic [P2_W-1:0]    p2_r;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_r;

  valve_t                valve_r, valve_nxt;
  logic [BC_W-1:0]       bc_r, bc_nxt, bc_inc;
  logic [STREAK_W-1:0]   low_r, low_nxt, high_r, high_nxt, low_adv, high_adv;
  logic [FLOW_W-1:0]     flow_r, flow_nxt, latch_r, latch_nxt, flow_q;
  logic                  updated;

  valve_t            ceil_lim, floor_lim, boosted, up_val, dn_val, tuned;
  sum_t              boost_sum, up_sum;
  logic              is_low, is_high, low_fire, high_fire, active_f;
  logic [PCT_W-1:0]  err_pct;
  logic [STEP_W-1:0] step;

  logic [DRIVE_W-1:0] drive_r;
  logic               upd_r, tune_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_blend_r      <= DEF_BLEND;
      cfg_peak_flow_r  <= DEF_PEAK_FLOW;
      cfg_step_small_r <= DEF_STEP_SMALL;
      cfg_step_mid_r   <= DEF_STEP_MID;
      cfg_step_large_r <= DEF_STEP_LARGE;
      cfg_boost_r      <= DEF_BOOST;
      cfg_ceiling_r    <= DEF_CEILING;
      cfg_floor_r      <= DEF_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLEND_METHOD:  cfg_blend_r      <= cfg_wdata[0];
        CFG_PEAK_FLOW:     cfg_peak_flow_r  <= cfg_wdata[FLOW_W-1:0];
        CFG_STEP_SMALL:    cfg_step_small_r <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_MID:      cfg_step_mid_r   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_LARGE:    cfg_step_large_r <= cfg_wdata[STEP_W-1:0];
        CFG_BOOST_STEP:    cfg_boost_r      <= cfg_wdata[STEP_W-1:0];
        CFG_VALVE_CEILING: cfg_ceiling_r    <= cfg_wdata[VALVE_CFG_W-1:0];
        CFG_VALVE_FLOOR:   cfg_floor_r      <= cfg_wdata[VALVE_CFG_W-1:0];
        default: cfg_blend_r <= cfg_blend_r;
      endcase
    end
  end

  // Both methods share one chain: volume uses avg * 300 so the final divide is by 30000.
  assign fk = 9'(in_fio2_set) + ((in_fio2_set >= FIO2_K_SWITCH) ? K_HIGH_FIO2 : K_LOW_FIO2);
  assign p1_nxt = cfg_blend_r ? (P1_W'(in_mean_flow) * P1_W'(VOL_SCALE))
                              : (P1_W'(fk) * P1_W'(cfg_peak_flow_r));
  assign prod = PROD_W'(p2_r) * PROD_W'(RECIP_30000);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      fio2_r <= in_fio2_set;
      ach_r  <= in_o2_measured;
      avg_r  <= in_mean_flow;
      chk_r  <= in_check_count;
      load_r <= in_valve_load;
      p1_r   <= p1_nxt;
    end
    if (cmd.mul2) begin
      p2_r <= P2_W'(p1_r) * P2_W'(fio2_r - FIO2_AMBIENT);
    end
    if (cmd.mul3) begin
      q_r <= prod[RECIP_SHIFT +: Q_W];
    end
  end

  assign ceil_lim  = (lim_t'(cfg_ceiling_r) > lim_t'(VALVE_MAX)) ? VALVE_MAX
                                                                 : valve_t'(cfg_ceiling_r);
  assign floor_lim = (lim_t'(cfg_floor_r) > lim_t'(VALVE_MAX)) ? VALVE_MAX
                                                               : valve_t'(cfg_floor_r);

  assign bc_inc    = (bc_r >= BREATH_SAT) ? BREATH_SAT : bc_r + 4'd1;
  assign boost_sum = sum_t'(valve_r) + sum_t'(cfg_boost_r);
  assign boosted   = (bc_inc != BOOST_BREATH) ? valve_r :
                     (boost_sum > sum_t'(VALVE_MAX)) ? VALVE_MAX : valve_t'(boost_sum);

  assign is_low  = (8'(ach_r) + 8'd1) < 8'(fio2_r);
  assign is_high = ach_r > fio2_r;
  assign err_pct = is_low ? (fio2_r - ach_r) : (ach_r - fio2_r);
  assign step    = (err_pct <= BAND_SMALL) ? cfg_step_small_r :
                   (err_pct <= BAND_MID)   ? cfg_step_mid_r   : cfg_step_large_r;

  assign up_sum = sum_t'(boosted) + sum_t'(step);
  assign up_val = (up_sum > sum_t'(VALVE_MAX)) ? VALVE_MAX : valve_t'(up_sum);
  assign dn_val = (sum_t'(boosted) > sum_t'(step)) ? valve_t'(sum_t'(boosted) - sum_t'(step))
                                                   : '0;

  assign low_adv   = low_r + 2'd1;
  assign high_adv  = high_r + 2'd1;
  assign low_fire  = low_adv > 2'd1;
  assign high_fire = high_adv > 2'd1;

  always_comb begin
    tuned = boosted;
    if (is_low) begin
      tuned = low_fire ? up_val : boosted;
      if (tuned >= ceil_lim) begin
        tuned = ceil_lim;
      end
    end else if (is_high) begin
      tuned = high_fire ? dn_val : boosted;
      if (tuned <= floor_lim) begin
        tuned = floor_lim;
      end
    end
  end

  assign flow_q = (q_r > Q_W'(FLOW_MAX)) ? FLOW_MAX :
                  (q_r <= Q_W'(FLOW_MIN)) ? FLOW_MIN : q_r[FLOW_W-1:0];

  assign active_f = fio2_r > FIO2_AMBIENT;

  always_comb begin
    valve_nxt = valve_r;
    bc_nxt    = bc_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    flow_nxt  = flow_r;
    latch_nxt = latch_r;
    updated   = 1'b0;
    if (mode_r) begin
      valve_nxt = valve_t'(load_r);
    end else if (active_f) begin
      bc_nxt = bc_inc;
      if (bc_inc >= BOOST_BREATH) begin
        valve_nxt = tuned;
        if (is_low) begin
          low_nxt  = low_fire ? '0 : low_adv;
          high_nxt = '0;
        end else if (is_high) begin
          high_nxt = high_fire ? '0 : high_adv;
          low_nxt  = '0;
        end
      end else begin
        valve_nxt = boosted;
        if (chk_r < CHECK_LIMIT) begin
          flow_nxt  = flow_q;
          latch_nxt = avg_r;
          updated   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_r <= '0;
      bc_r    <= '0;
      low_r   <= '0;
      high_r  <= '0;
      flow_r  <= '0;
      latch_r <= '0;
    end else if (cmd.commit) begin
      valve_r <= valve_nxt;
      bc_r    <= bc_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      flow_r  <= flow_nxt;
      latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_r <= active_f ? DRIVE_W'(valve_nxt) : '0;
      upd_r   <= updated;
      tune_r  <= bc_nxt >= BOOST_BREATH;
    end
  end

  assign out_valve_drive   = drive_r;
  assign out_target_flow   = flow_r;
  assign out_flow_updated  = upd_r;
  assign out_tuning_active = tune_r;
  assign out_held_flow     = latch_r;

endmodule

FILE: design/per_breath_oxygen_valve_tuner_top.sv
// Top level of the per-breath oxygen valve tuner.
// Instantiates pbovt_ctrl and pbovt_dp; depends on pbovt_pkg.
//
// One input transfer per breath. An item with mode 0 is the end-of-breath
// update: during the first nine breaths it recomputes the oxygen flow target
// while the check count is below four, at the tenth it adds the boost step to
// the valve value, and from the tenth on it nudges that value by a banded step
// after two low or two high breaths. An item with mode 1 loads the valve value.
// Each item yields one result. The flow target goes through three registered
// multiplies, the last by a reciprocal of 30000; in_ready is high only in
// idle, so no new item is taken before the last is committed. The result sits
// in an output register; while the receiver stalls the controller waits in its
// commit step and holds in_ready low, and no result is dropped. The user writes
// configuration registers through cfg_we, cfg_index and cfg_wdata only while
// the block is idle; the block does not enforce this. Synchronous reset loads
// the register defaults, clears the valve value, counters and flow target, and
// empties the output register.
module per_breath_oxygen_valve_tuner_top #(
  parameter int VALVE_BITS = pbovt_pkg::VALVE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pbovt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbovt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [pbovt_pkg::PCT_W-1:0]       in_fio2_set,
  input  logic [pbovt_pkg::PCT_W-1:0]       in_o2_measured,
  input  logic [pbovt_pkg::FLOW_W-1:0]      in_mean_flow,
  input  logic [pbovt_pkg::CHK_W-1:0]       in_check_count,
  input  logic [pbovt_pkg::VALVE_CFG_W-1:0] in_valve_load,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbovt_pkg::DRIVE_W-1:0]     out_valve_drive,
  output logic [pbovt_pkg::FLOW_W-1:0]      out_target_flow,
  output logic                              out_flow_updated,
  output logic                              out_tuning_active,
  output logic [pbovt_pkg::FLOW_W-1:0]      out_held_flow
);
  import pbovt_pkg::*;

  dp_cmd_t cmd;

  pbovt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pbovt_dp #(
    .VALVE_BITS (VALVE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_mode),
    .in_fio2_set        (in_fio2_set),
    .in_o2_measured     (in_o2_measured),
    .in_mean_flow       (in_mean_flow),
    .in_check_count     (in_check_count),
    .in_valve_load      (in_valve_load),
    .out_valve_drive    (out_valve_drive),
    .out_target_flow    (out_target_flow),
    .out_flow_updated   (out_flow_updated),
    .out_tuning_active  (out_tuning_active),
    .out_held_flow      (out_held_flow)
  );

endmodule
